// ===== rtl/core/websocket_frame_receive_parser_macros.svh =====
// Assertion helpers shared by the parser RTL.
`ifndef WEBSOCKET_FRAME_RECEIVE_PARSER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVE_PARSER_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define WSFRP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define WSFRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/wsfrp_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Shared types and codes of the frame parser.
// ----------------------------------------------------------------------------
package wsfrp_pkg;
	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_MASK = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	localparam logic [1:0] EV_PAYLOAD = 2'd0;
	localparam logic [1:0] EV_EMPTY   = 2'd1;
	localparam logic [1:0] EV_ERROR   = 2'd2;

	localparam logic [2:0] ERR_RSV     = 3'd0;
	localparam logic [2:0] ERR_STRAY   = 3'd1;
	localparam logic [2:0] ERR_UNEXP   = 3'd2;
	localparam logic [2:0] ERR_CLOSING = 3'd3;
	localparam logic [2:0] ERR_CTRL    = 3'd4;
	localparam logic [2:0] ERR_SIZE    = 3'd5;
	localparam logic [2:0] ERR_OPCODE  = 3'd6;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	localparam logic [1:0] MSG_NONE = 2'd0;

	localparam logic [0:0] REG_MAX_BYTES = 1'b0;
	localparam logic [0:0] REG_CLOSING   = 1'b1;

	localparam logic [31:0] MAX_BYTES_RST = 32'h0100_0000;
	localparam logic [6:0]  LEN_CTRL_MAX  = 7'd125;
	localparam logic [6:0]  LEN_EXT16     = 7'd126;
	localparam logic [6:0]  LEN_EXT64     = 7'd127;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic [1:0] message_kind;
		logic       final_fragment;
		logic       frame_last;
		logic [2:0] error_code;
	} result_t;

	typedef struct packed {
		logic emit;
		logic error_latched;
	} front_status_t;
endpackage

// ===== rtl/core/wsfrp_front.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser front end
// Takes one byte per cycle while take is high, parses headers and unmasks payload bytes.
// ----------------------------------------------------------------------------
module wsfrp_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [7:0]              rx_byte,
	input  logic                    cfg_we,
	input  logic [0:0]              cfg_index,
	input  logic [31:0]             cfg_data,
	output wsfrp_pkg::result_t      rslt,
	output wsfrp_pkg::front_status_t status
);
	import wsfrp_pkg::*;

	logic [31:0] max_bytes_q;
	logic        closing_q;
	logic [2:0]  phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        fin_q, fin_d;
	logic [1:0]  msg_q, msg_d;
	logic [2:0]  ext_cnt_q, ext_cnt_d;
	logic [63:0] remain_q, remain_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  kpos_q, kpos_d;
	logic [32:0] mbytes_q, mbytes_d;
	logic        err_q, err_d;
	logic        emit;

	logic [63:0] len_full;
	logic [33:0] sum;
	logic [32:0] sum_sat;
	logic        len_over;
	logic        ctrl_op, new_ctrl;
	logic [3:0]  op_in;
	logic [7:0]  key_byte;
	logic [63:0] remain_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RST;
			closing_q   <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MAX_BYTES) max_bytes_q <= cfg_data;
			else closing_q <= cfg_data[0];
		end
	end

	assign ctrl_op  = (opcode_q == OP_CLOSE) || (opcode_q == OP_PING) || (opcode_q == OP_PONG);
	assign op_in    = rx_byte[3:0];
	assign new_ctrl = (op_in == OP_CLOSE) || (op_in == OP_PING) || (op_in == OP_PONG);
	assign remain_dec = remain_q - 64'd1;

	// Length as it stands once the last length byte is in.
	assign len_full = (phase_q == PH_HDR1) ? {57'd0, rx_byte[6:0]} : {remain_q[55:0], rx_byte};
	assign sum      = {1'b0, len_full[32:0]} + {1'b0, mbytes_q};
	assign sum_sat  = ((|len_full[63:33]) || sum[33]) ? '1 : sum[32:0];

	always_comb begin
		if (ctrl_op) len_over = (|len_full[63:32]) || (len_full[31:0] > max_bytes_q);
		else len_over = sum_sat > {1'b0, max_bytes_q};
	end

	always_comb begin
		case (kpos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		fin_d     = fin_q;
		msg_d     = msg_q;
		ext_cnt_d = ext_cnt_q;
		remain_d  = remain_q;
		key_d     = key_q;
		kpos_d    = kpos_q;
		mbytes_d  = mbytes_q;
		err_d     = err_q;
		emit      = 1'b0;
		rslt.event_kind     = EV_ERROR;
		rslt.payload_byte   = 8'd0;
		rslt.frame_opcode   = opcode_q;
		rslt.message_kind   = msg_q;
		rslt.final_fragment = fin_q;
		rslt.frame_last     = 1'b0;
		rslt.error_code     = ERR_RSV;
		if (take && !err_q) begin
			unique case (phase_q) inside
				PH_HDR1, PH_EXT: begin
					remain_d = len_full;
					if (phase_q == PH_HDR1 && ctrl_op &&
					    (!fin_q || rx_byte[6:0] > LEN_CTRL_MAX)) begin
						emit = 1'b1;
						rslt.error_code = ERR_CTRL;
					end else if (phase_q == PH_HDR1 && rx_byte[6:0] == LEN_EXT16) begin
						remain_d  = '0;
						ext_cnt_d = 3'd1;
						phase_d   = PH_EXT;
					end else if (phase_q == PH_HDR1 && rx_byte[6:0] == LEN_EXT64) begin
						remain_d  = '0;
						ext_cnt_d = 3'd7;
						phase_d   = PH_EXT;
					end else if (phase_q == PH_EXT && ext_cnt_q != 3'd0) begin
						ext_cnt_d = ext_cnt_q - 3'd1;
					end else begin
						if (!ctrl_op) mbytes_d = sum_sat;
						if (len_over) begin
							emit = 1'b1;
							rslt.error_code = ERR_SIZE;
						end else begin
							key_d   = '0;
							kpos_d  = 2'd0;
							phase_d = PH_MASK;
						end
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], rx_byte};
					if (kpos_q != 2'd3) begin
						kpos_d = kpos_q + 2'd1;
					end else begin
						kpos_d = 2'd0;
						if (remain_q == 64'd0) begin
							emit = 1'b1;
							rslt.event_kind = EV_EMPTY;
							rslt.frame_last = 1'b1;
							phase_d = PH_HDR0;
							if ((opcode_q <= OP_BIN && fin_q) || opcode_q == OP_CLOSE) begin
								msg_d    = MSG_NONE;
								mbytes_d = '0;
							end
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					emit = 1'b1;
					kpos_d   = kpos_q + 2'd1;
					remain_d = remain_dec;
					rslt.event_kind   = EV_PAYLOAD;
					rslt.payload_byte = rx_byte ^ key_byte;
					rslt.frame_last   = (remain_dec == 64'd0);
					if (remain_dec == 64'd0) begin
						phase_d = PH_HDR0;
						if ((opcode_q <= OP_BIN && fin_q) || opcode_q == OP_CLOSE) begin
							msg_d    = MSG_NONE;
							mbytes_d = '0;
						end
					end
				end
				default: begin
					// Unused phase codes behave as the first header byte.
					fin_d    = rx_byte[7];
					opcode_d = op_in;
					rslt.frame_opcode   = op_in;
					rslt.final_fragment = rx_byte[7];
					emit = 1'b1;
					if (|rx_byte[6:4]) rslt.error_code = ERR_RSV;
					else if (msg_q == MSG_NONE && op_in == OP_CONT) rslt.error_code = ERR_STRAY;
					else if (msg_q != MSG_NONE && !new_ctrl && op_in != OP_CONT)
						rslt.error_code = ERR_UNEXP;
					else if (op_in > OP_BIN && !new_ctrl) rslt.error_code = ERR_OPCODE;
					else if (closing_q && op_in != OP_CLOSE) rslt.error_code = ERR_CLOSING;
					else begin
						emit = 1'b0;
						if (op_in == OP_TEXT || op_in == OP_BIN) msg_d = op_in[1:0];
						phase_d = PH_HDR1;
					end
				end
			endcase
			if (emit && rslt.event_kind == EV_ERROR) err_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			opcode_q  <= '0;
			fin_q     <= 1'b0;
			msg_q     <= MSG_NONE;
			ext_cnt_q <= '0;
			remain_q  <= '0;
			key_q     <= '0;
			kpos_q    <= '0;
			mbytes_q  <= '0;
			err_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			opcode_q  <= opcode_d;
			fin_q     <= fin_d;
			msg_q     <= msg_d;
			ext_cnt_q <= ext_cnt_d;
			remain_q  <= remain_d;
			key_q     <= key_d;
			kpos_q    <= kpos_d;
			mbytes_q  <= mbytes_d;
			err_q     <= err_d;
		end
	end

	assign status.emit          = emit;
	assign status.error_latched = err_q;
endmodule

// ===== rtl/core/wsfrp_queue.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser result queue
// Small register queue that holds results until the consumer pops them.
// ----------------------------------------------------------------------------
module wsfrp_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  wsfrp_pkg::result_t wr_data,
	input  logic               rd,
	output wsfrp_pkg::result_t rd_data,
	output logic               full,
	output logic               empty
);
	import wsfrp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	result_t       mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + PW'(1);
			if (do_rd) rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + PW'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - CW'(1);
		end
	end
endmodule

// ===== rtl/core/websocket_frame_receive_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame receive parser
// Parses received frames byte by byte and queues unmasked payload, empty-frame events and errors.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Content
// input     in         push / full      rx_byte
// result    out        empty / pop      event and frame fields
// config    in         cfg_we           cfg_index, cfg_data
//
// One byte is taken every cycle while push is high and the result queue has room;
// each byte yields at most one result, written to the queue at the edge that takes it.
// Results are registered in a queue of QUEUE_DEPTH entries whose head drives the ports.
// A full queue holds off push; full clears in the cycle after a pop.
// Reset clears the parser state and the queue and returns the registers to their reset values at once.
// ----------------------------------------------------------------------------
`include "websocket_frame_receive_parser_macros.svh"
module websocket_frame_receive_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  event_kind,
	output logic [7:0]  payload_byte,
	output logic [3:0]  frame_opcode,
	output logic [1:0]  message_kind,
	output logic        final_fragment,
	output logic        frame_last,
	output logic [2:0]  error_code,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import wsfrp_pkg::*;

	result_t       front_res, out_res;
	front_status_t front_st;
	logic          take;

	assign take = push && !full;

	wsfrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.rx_byte  (rx_byte),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rslt     (front_res),
		.status   (front_st)
	);

	wsfrp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_st.emit),
		.wr_data(front_res),
		.rd     (pop),
		.rd_data(out_res),
		.full   (full),
		.empty  (empty)
	);

	assign event_kind     = out_res.event_kind;
	assign payload_byte   = out_res.payload_byte;
	assign frame_opcode   = out_res.frame_opcode;
	assign message_kind   = out_res.message_kind;
	assign final_fragment = out_res.final_fragment;
	assign frame_last     = out_res.frame_last;
	assign error_code     = out_res.error_code;

	`WSFRP_ASSERT_NOW(a_no_emit_when_full, full, !front_st.emit, "result made while queue full")
	`WSFRP_ASSERT_NOW(a_silent_after_error, front_st.error_latched, !front_st.emit, "result after error")
	`WSFRP_ASSERT_NEXT(a_error_latches, front_st.emit && front_res.event_kind == EV_ERROR, front_st.error_latched, "error did not latch")
	`WSFRP_ASSERT_NEXT(a_queue_gets_item, front_st.emit && empty, !empty, "result lost on the way to the queue")
endmodule
